// ===== rtl/pmu_pkg.sv =====
package pmu_pkg;

  localparam int MAX_TERMS   = 16;
  localparam int COEFF_WIDTH = 16;

  localparam int IN_W   = 16;
  localparam int ACC_W  = 36;
  localparam int DEG_W  = 5;
  localparam int IDX_W  = $clog2(MAX_TERMS);
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int I_W    = $clog2(2 * MAX_TERMS);
  localparam int PROD_W = 2 * COEFF_WIDTH;
  localparam int PC_W   = 3;

  localparam logic [PC_W-1:0] STEP_IDLE   = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_SETUP  = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_READ   = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_MUL    = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_ACC    = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_EMIT   = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_FINISH = PC_W'(6);

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_NO_TRIGGER,
    JC_J_MORE,
    JC_I_MORE,
    JC_ALWAYS
  } jump_t;

  typedef struct packed {
    logic              accept;
    logic              clr_acc;
    logic              mul_en;
    logic              acc_en;
    logic              j_inc;
    logic              j_clr;
    logic              i_inc;
    logic              i_clr;
    logic              emit;
    logic              finish;
    logic              wait_out;
    jump_t             jc;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic trigger;
    logic j_more;
    logic i_more;
    logic out_blocked;
  } status_t;

  localparam ctrl_t CTRL_NOP = '0;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.jc     = JC_NO_TRIGGER;
        w.target = STEP_IDLE;
      end
      STEP_SETUP: begin
        w.clr_acc = 1'b1;
        w.j_clr   = 1'b1;
        w.i_clr   = 1'b1;
      end
      STEP_READ: begin
        w.jc = JC_NEXT;
      end
      STEP_MUL: begin
        w.mul_en = 1'b1;
      end
      STEP_ACC: begin
        w.acc_en = 1'b1;
        w.j_inc  = 1'b1;
        w.jc     = JC_J_MORE;
        w.target = STEP_READ;
      end
      STEP_EMIT: begin
        w.wait_out = 1'b1;
        w.emit     = 1'b1;
        w.clr_acc  = 1'b1;
        w.j_clr    = 1'b1;
        w.i_inc    = 1'b1;
        w.jc       = JC_I_MORE;
        w.target   = STEP_READ;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.jc     = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pmu_ram.sv =====
module pmu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pmu_sequencer.sv =====
module pmu_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  pmu_pkg::status_t  status,
  output pmu_pkg::ctrl_t    ctrl
);

  logic [pmu_pkg::PC_W-1:0] pc;
  logic [pmu_pkg::PC_W-1:0] pc_next;
  pmu_pkg::ctrl_t           word;
  logic                     hold;

  assign word = pmu_pkg::rom_word(pc);
  assign hold = word.wait_out && status.out_blocked;
  assign ctrl = hold ? pmu_pkg::CTRL_NOP : word;

  always_comb begin
    pc_next = pc + pmu_pkg::PC_W'(1);
    if (hold) begin
      pc_next = pc;
    end else begin
      unique case (word.jc)
        pmu_pkg::JC_NEXT:       pc_next = pc + pmu_pkg::PC_W'(1);
        pmu_pkg::JC_NO_TRIGGER: if (!status.trigger) pc_next = word.target;
        pmu_pkg::JC_J_MORE:     if (status.j_more) pc_next = word.target;
        pmu_pkg::JC_I_MORE:     if (status.i_more) pc_next = word.target;
        pmu_pkg::JC_ALWAYS:     pc_next = word.target;
        default:                pc_next = pmu_pkg::STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pmu_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/pmu_datapath.sv =====
module pmu_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  pmu_pkg::ctrl_t                    ctrl,
  output pmu_pkg::status_t                  status,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              func,
  input  logic signed [pmu_pkg::IN_W-1:0]   coeff,
  input  logic                              last_term,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [pmu_pkg::ACC_W-1:0]  product_coeff,
  output logic [pmu_pkg::DEG_W-1:0]         degree,
  output logic                              run_end,
  output logic                              dropped
);

  localparam logic [pmu_pkg::CNT_W-1:0] CNT_MAX = pmu_pkg::CNT_W'(pmu_pkg::MAX_TERMS);

  logic [pmu_pkg::CNT_W-1:0]        first_count;
  logic [pmu_pkg::CNT_W-1:0]        second_count;
  logic                             overflow_seen;
  logic [pmu_pkg::IDX_W-1:0]        j;
  logic [pmu_pkg::I_W-1:0]          i;
  logic signed [pmu_pkg::PROD_W-1:0] prod;
  logic signed [pmu_pkg::PROD_W-1:0] term_prod;
  logic signed [pmu_pkg::ACC_W-1:0] acc;

  logic                             xfer;
  logic                             wr_first;
  logic                             wr_second;
  logic [pmu_pkg::COEFF_WIDTH-1:0]  wdata;
  logic [pmu_pkg::COEFF_WIDTH-1:0]  rd_first;
  logic [pmu_pkg::COEFF_WIDTH-1:0]  rd_second;
  logic [pmu_pkg::IDX_W-1:0]        jlast;
  logic [pmu_pkg::I_W-1:0]          ilast;
  logic [pmu_pkg::I_W:0]            span;
  logic [pmu_pkg::I_W-1:0]          diff;
  logic                             term_ok;
  logic                             first_empty;

  assign item_stall = !ctrl.accept;
  assign xfer       = item_valid && ctrl.accept;
  assign wr_first   = xfer && !func && (first_count < CNT_MAX);
  assign wr_second  = xfer && func && (second_count < CNT_MAX);
  assign wdata      = pmu_pkg::COEFF_WIDTH'(coeff);

  // an empty first polynomial still runs one masked pass giving a zero result
  assign first_empty = (first_count == '0);
  assign jlast = first_empty ? '0 : pmu_pkg::IDX_W'(first_count - pmu_pkg::CNT_W'(1));
  assign span  = (pmu_pkg::I_W + 1)'(first_count) + (pmu_pkg::I_W + 1)'(second_count)
               - (pmu_pkg::I_W + 1)'(2);
  assign ilast = first_empty ? '0 : span[pmu_pkg::I_W-1:0];

  assign diff    = i - pmu_pkg::I_W'(j);
  assign term_ok = (pmu_pkg::CNT_W'(j) < first_count) && (pmu_pkg::I_W'(j) <= i)
                && (diff < pmu_pkg::I_W'(second_count));

  assign term_prod = $signed(rd_first) * $signed(rd_second);

  assign status.trigger     = xfer && func && last_term;
  assign status.j_more      = (j != jlast);
  assign status.i_more      = (i != ilast);
  assign status.out_blocked = result_valid && result_stall;

  pmu_ram #(
    .WIDTH(pmu_pkg::COEFF_WIDTH),
    .DEPTH(pmu_pkg::MAX_TERMS)
  ) u_first_ram (
    .clk  (clk),
    .we   (wr_first),
    .waddr(first_count[pmu_pkg::IDX_W-1:0]),
    .wdata(wdata),
    .raddr(j),
    .rdata(rd_first)
  );

  pmu_ram #(
    .WIDTH(pmu_pkg::COEFF_WIDTH),
    .DEPTH(pmu_pkg::MAX_TERMS)
  ) u_second_ram (
    .clk  (clk),
    .we   (wr_second),
    .waddr(second_count[pmu_pkg::IDX_W-1:0]),
    .wdata(wdata),
    .raddr(diff[pmu_pkg::IDX_W-1:0]),
    .rdata(rd_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (ctrl.finish) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (xfer) begin
      if (wr_first) begin
        first_count <= first_count + pmu_pkg::CNT_W'(1);
      end
      if (wr_second) begin
        second_count <= second_count + pmu_pkg::CNT_W'(1);
      end
      if (!wr_first && !wr_second) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.j_clr) begin
      j <= '0;
    end else if (ctrl.j_inc) begin
      j <= j + pmu_pkg::IDX_W'(1);
    end
    if (ctrl.i_clr) begin
      i <= '0;
    end else if (ctrl.i_inc) begin
      i <= i + pmu_pkg::I_W'(1);
    end
    if (ctrl.mul_en) begin
      prod <= term_ok ? term_prod : '0;
    end
    if (ctrl.clr_acc) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + pmu_pkg::ACC_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      product_coeff <= acc;
      degree        <= pmu_pkg::DEG_W'(i);
      run_end       <= (i == ilast);
      dropped       <= overflow_seen;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> !(result_valid && result_stall))
    else $error("result overwritten while stalled");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (first_count <= CNT_MAX) && (second_count <= CNT_MAX))
    else $error("coefficient count beyond capacity");

  a_last_then_finish: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && (i == ilast)) |=> ctrl.finish)
    else $error("run did not end after final result");

  a_j_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.mul_en |-> (j <= jlast))
    else $error("term index past last term");

endmodule

// ===== rtl/polynomial_multiplier_unit.sv =====
// a load transfer is accepted only while idle; the last second-polynomial transfer starts a run
// each result is emitted after one pass over the first polynomial's terms (masked when it is empty)
// a run emits n3 = n1+n2-1 results (1 when the first is empty) and holds the input stalled
// until it ends, including any output stall
// the single shared multiply-accumulate takes each term in turn through its read, multiply and accumulate steps
// synchronous active-high reset clears the counts, drop flag, sequencer and output valid
module polynomial_multiplier_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              func,
  input  logic signed [pmu_pkg::IN_W-1:0]   coeff,
  input  logic                              last_term,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [pmu_pkg::ACC_W-1:0]  product_coeff,
  output logic [pmu_pkg::DEG_W-1:0]         degree,
  output logic                              run_end,
  output logic                              dropped
);

  pmu_pkg::ctrl_t   ctrl;
  pmu_pkg::status_t status;

  pmu_sequencer u_sequencer (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .ctrl  (ctrl)
  );

  pmu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .coeff        (coeff),
    .last_term    (last_term),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .product_coeff(product_coeff),
    .degree       (degree),
    .run_end      (run_end),
    .dropped      (dropped)
  );

endmodule
